// ===== src/snm_pkg.sv =====
// ----------------------------------------------------------------------------
// snm_pkg
// Shared types and constants for the Sobel non-maximum suppression block.
// ----------------------------------------------------------------------------
package snm_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);

    // register indexes on the configuration port
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // tan(22.5) and tan(67.5) in unsigned Q12.24
    localparam logic [35:0] TAN_LOW_Q24  = 36'd6949350;
    localparam logic [35:0] TAN_HIGH_Q24 = 36'd40503782;

    // direction sectors
    localparam logic [1:0] SEC_HORIZ = 2'd0;
    localparam logic [1:0] SEC_POS45 = 2'd1;
    localparam logic [1:0] SEC_VERT  = 2'd2;
    localparam logic [1:0] SEC_NEG45 = 2'd3;

    // one line memory word: two pixel rows, two magnitude rows, one sector
    typedef struct packed {
        logic [1:0] sec;
        logic [7:0] mag1;
        logic [7:0] mag0;
        logic [7:0] pix1;
        logic [7:0] pix0;
    } line_word_t;

    // handshake with the magnitude unit
    typedef struct packed {
        logic              start;
        logic signed [10:0] gv;
        logic signed [10:0] gh;
    } mag_req_t;

    typedef struct packed {
        logic       done;
        logic [7:0] mag;
        logic [1:0] sec;
    } mag_rsp_t;

endpackage

// ===== src/snm_line_mem.sv =====
// ----------------------------------------------------------------------------
// snm_line_mem
// Column-indexed line memory, one registered read port and one write port.
// ----------------------------------------------------------------------------
module snm_line_mem
    import snm_pkg::*;
(
    input  logic             clk,
    input  logic             rd_en,
    input  logic [COL_W-1:0] rd_addr,
    output line_word_t       rd_data,
    input  logic             wr_en,
    input  logic [COL_W-1:0] wr_addr,
    input  line_word_t       wr_data
);

    line_word_t mem [MAX_WIDTH];
    line_word_t rd_data_reg;

    // synchronous read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/snm_mag_unit.sv =====
// ----------------------------------------------------------------------------
// snm_mag_unit
// Gradient magnitude by a bit-per-cycle square root, and direction sector.
// ----------------------------------------------------------------------------
module snm_mag_unit
    import snm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mag_req_t req,
    output mag_rsp_t rsp
);

    typedef enum logic [2:0] {
        P_IDLE   = 3'b001,
        P_SQUARE = 3'b010,
        P_ROOT   = 3'b100
    } phase_t;

    phase_t       phase_reg, phase_next;
    logic [2:0]   step_reg, step_next;
    logic         done_reg, done_next;
    logic [7:0]   root_reg, root_next;
    logic [9:0]   av_reg, ah_reg;
    logic         gv_zero_reg, same_sign_reg;
    logic [20:0]  sq_reg;
    logic [35:0]  lhs_reg, lo_reg, hi_reg;
    logic [9:0]   av, ah;
    logic [7:0]   trial;
    logic [15:0]  trial_sq;
    logic [1:0]   sec;

    // absolute values of the incoming gradients
    assign av = req.gv[10] ? 10'(-req.gv) : req.gv[9:0];
    assign ah = req.gh[10] ? 10'(-req.gh) : req.gh[9:0];

    // capture operands on start
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            av_reg        <= av;
            ah_reg        <= ah;
            gv_zero_reg   <= (req.gv == 11'sd0);
            same_sign_reg <= ((req.gh > 11'sd0) == (req.gv > 11'sd0));
        end
        if (phase_reg == P_SQUARE)
        begin
            sq_reg  <= 21'(av_reg * av_reg) + 21'(ah_reg * ah_reg);
            lhs_reg <= {2'b00, ah_reg, 24'd0};
            lo_reg  <= 36'(av_reg * TAN_LOW_Q24);
            hi_reg  <= 36'(av_reg * TAN_HIGH_Q24);
        end
    end

    // one root bit per cycle
    assign trial    = root_reg | (8'd1 << step_reg);
    assign trial_sq = trial * trial;

    always_comb
    begin
        phase_next = phase_reg;
        step_next  = step_reg;
        root_next  = root_reg;
        done_next  = 1'b0;
        case (phase_reg)
            P_IDLE:
            begin
                if (req.start)
                begin
                    phase_next = P_SQUARE;
                end
            end
            P_SQUARE:
            begin
                phase_next = P_ROOT;
                step_next  = 3'd7;
                root_next  = 8'd0;
            end
            P_ROOT:
            begin
                if (21'(trial_sq) <= sq_reg)
                begin
                    root_next = trial;
                end
                step_next = step_reg - 3'd1;
                if (step_reg == 3'd0)
                begin
                    phase_next = P_IDLE;
                    done_next  = 1'b1;
                end
            end
            default:
            begin
                phase_next = P_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_IDLE;
            step_reg  <= 3'd0;
            root_reg  <= 8'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            step_reg  <= step_next;
            root_reg  <= root_next;
            done_reg  <= done_next;
        end
    end

    // sector from the registered products
    always_comb
    begin
        if (gv_zero_reg)
        begin
            sec = SEC_VERT;
        end
        else if (lhs_reg <= lo_reg)
        begin
            sec = SEC_HORIZ;
        end
        else if (lhs_reg > hi_reg)
        begin
            sec = SEC_VERT;
        end
        else
        begin
            sec = same_sign_reg ? SEC_POS45 : SEC_NEG45;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.mag  = (sq_reg >= 21'd65025) ? 8'd255 : root_reg;
    assign rsp.sec  = sec;

endmodule

// ===== src/sobel_nonmax_suppression.sv =====
// ----------------------------------------------------------------------------
// sobel_nonmax_suppression
// Sobel gradient magnitude with non-maximum suppression on a pixel stream.
// ----------------------------------------------------------------------------
// One pixel item is taken at a time; the next is taken only after the last
// has gone through a line memory read, the Sobel sums, a squaring step, the
// bit-per-cycle square root, write back and result load. Results come two
// rows and two columns behind the input, only for input row and column 4 and
// up, so each frame shrinks by four per axis. The line memory holds no reset
// value; the first four rows and columns of a frame give no results, so no
// result depends on an entry that was never written.
module sobel_nonmax_suppression
    import snm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [12:0] cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] pixel
    input  logic        s_tuser,   // [0] frame_start
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] edge_strength
    output logic        m_tlast,   // row_end
    output logic        m_tuser    // [0] frame_end
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_READ = 6'b000010,
        S_GRAD = 6'b000100,
        S_MAG  = 6'b001000,
        S_OUT  = 6'b010000,
        S_HOLD = 6'b100000
    } state_t;

    state_t           state_reg, state_next;
    logic [10:0]      width_reg;
    logic [12:0]      height_reg;
    logic [COL_W-1:0] col_reg, col_next, ci_reg, col_cur;
    logic [ROW_W-1:0] row_reg, row_next, row_cur;
    logic [7:0]       pix_reg;
    logic             produce_reg, row_end_reg, frame_end_reg;
    logic [7:0]       pw [3][3];
    logic [7:0]       mw [3][3];
    logic [1:0]       sec_delay_reg, centre_sec_reg;
    logic             out_valid_reg;
    logic [7:0]       out_data_reg;
    logic             out_last_reg, out_user_reg;
    logic             accept, row_end, frame_end;
    logic [10:0]      w_eff;
    logic [12:0]      h_eff;
    line_word_t       rd_word, wr_word;
    mag_req_t         mreq;
    mag_rsp_t         mrsp;
    logic signed [11:0] gv_full, gh_full;
    logic [7:0]       centre, n1, n2, result;
    logic             can_load;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 11'd1024;
            height_reg <= 13'd768;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data[10:0];
                REG_HEIGHT: height_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // clamped frame size
    assign w_eff = (width_reg < 11'd5) ? 11'd5 :
                   (width_reg > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : width_reg;
    assign h_eff = (height_reg < 13'd5) ? 13'd5 :
                   (height_reg > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : height_reg;

    // position of the accepted item
    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign col_cur   = s_tuser ? '0 : col_reg;
    assign row_cur   = s_tuser ? '0 : row_reg;
    assign row_end   = (11'(col_cur) >= w_eff - 11'd1);
    assign frame_end = row_end && (13'(row_cur) >= h_eff - 13'd1);

    always_comb
    begin
        col_next = col_cur + COL_W'(1);
        row_next = row_cur;
        if (row_end)
        begin
            col_next = '0;
            row_next = frame_end ? '0 : row_cur + ROW_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // item payload held while it is worked on
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix_reg       <= s_tdata;
            ci_reg        <= col_cur;
            row_end_reg   <= row_end;
            frame_end_reg <= frame_end;
            produce_reg   <= (row_cur >= ROW_W'(4)) && (col_cur >= COL_W'(4));
        end
    end

    // line memory
    assign wr_word.pix0 = pix_reg;
    assign wr_word.pix1 = rd_word.pix0;
    assign wr_word.mag0 = mrsp.mag;
    assign wr_word.mag1 = rd_word.mag0;
    assign wr_word.sec  = mrsp.sec;

    snm_line_mem u_line_mem (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (col_cur),
        .rd_data (rd_word),
        .wr_en   (state_reg == S_MAG && mrsp.done),
        .wr_addr (ci_reg),
        .wr_data (wr_word)
    );

    // pixel and magnitude windows, sector delay
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    pw[k][j] <= 8'd0;
                    mw[k][j] <= 8'd0;
                end
            end
            sec_delay_reg  <= SEC_HORIZ;
            centre_sec_reg <= SEC_HORIZ;
        end
        else
        begin
            if (state_reg == S_READ)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    pw[k][0] <= pw[k][1];
                    pw[k][1] <= pw[k][2];
                end
                pw[0][2] <= rd_word.pix1;
                pw[1][2] <= rd_word.pix0;
                pw[2][2] <= pix_reg;
            end
            if (state_reg == S_MAG && mrsp.done)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    mw[k][0] <= mw[k][1];
                    mw[k][1] <= mw[k][2];
                end
                mw[0][2]       <= rd_word.mag1;
                mw[1][2]       <= rd_word.mag0;
                mw[2][2]       <= mrsp.mag;
                centre_sec_reg <= sec_delay_reg;
                sec_delay_reg  <= rd_word.sec;
            end
        end
    end

    // sobel sums on the window centre
    assign gv_full = ($signed({4'd0, pw[2][0]}) + $signed({3'd0, pw[2][1], 1'b0})
                    + $signed({4'd0, pw[2][2]}))
                   - ($signed({4'd0, pw[0][0]}) + $signed({3'd0, pw[0][1], 1'b0})
                    + $signed({4'd0, pw[0][2]}));
    assign gh_full = ($signed({4'd0, pw[0][0]}) + $signed({3'd0, pw[1][0], 1'b0})
                    + $signed({4'd0, pw[2][0]}))
                   - ($signed({4'd0, pw[0][2]}) + $signed({3'd0, pw[1][2], 1'b0})
                    + $signed({4'd0, pw[2][2]}));

    assign mreq.start = (state_reg == S_GRAD);
    assign mreq.gv    = gv_full[10:0];
    assign mreq.gh    = gh_full[10:0];

    snm_mag_unit u_mag_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .rsp   (mrsp)
    );

    // suppression along the centre's sector
    always_comb
    begin
        centre = mw[1][1];
        case (centre_sec_reg)
            SEC_HORIZ:
            begin
                n1 = mw[0][1];
                n2 = mw[2][1];
            end
            SEC_VERT:
            begin
                n1 = mw[1][0];
                n2 = mw[1][2];
            end
            SEC_POS45:
            begin
                n1 = mw[2][2];
                n2 = mw[0][0];
            end
            default:
            begin
                n1 = mw[2][0];
                n2 = mw[0][2];
            end
        endcase
        result = (centre < n1 || centre < n2) ? 8'd0 : centre;
    end

    // sequencer
    assign can_load = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (accept) state_next = S_READ;
            S_READ: state_next = S_GRAD;
            S_GRAD: state_next = S_MAG;
            S_MAG:  if (mrsp.done) state_next = S_OUT;
            S_OUT:
            begin
                if (!produce_reg || can_load)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_HOLD;
                end
            end
            S_HOLD: if (can_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == S_OUT || state_reg == S_HOLD) && produce_reg && can_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_OUT || state_reg == S_HOLD) && produce_reg && can_load)
        begin
            out_data_reg <= result;
            out_last_reg <= row_end_reg;
            out_user_reg <= frame_end_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Streams pixel frames through the Sobel non-maximum suppression block at
// several image sizes, predicts every edge strength with a bit-true model
// kept in a scoreboard, and compares each output item field by field while
// both stream sides idle at random for part of the run.
// ----------------------------------------------------------------------------
module tb_top;
    import snm_pkg::*;

    typedef struct packed {
        logic [7:0] strength;
        logic       row_end;
        logic       frame_end;
    } edge_item_t;

    // edge strength predictor with its queue of pending edge items
    class edge_scoreboard;
        int unsigned width_reg;
        int unsigned height_reg;
        logic [7:0] pix_rows [2][MAX_WIDTH];
        logic [7:0] mag_rows [2][MAX_WIDTH];
        logic [1:0] sec_row [MAX_WIDTH];
        logic [7:0] pix_win [3][3];
        logic [7:0] mag_win [3][3];
        logic [1:0] sec_dly;
        int unsigned col_cnt;
        int unsigned row_cnt;
        edge_item_t pending_edges[$];
        int errors;

        function new();
            width_reg  = 1024;
            height_reg = 768;
            col_cnt    = 0;
            row_cnt    = 0;
            sec_dly    = SEC_HORIZ;
            errors     = 0;
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                begin
                    pix_win[i][j] = '0;
                    mag_win[i][j] = '0;
                end
        endfunction

        function void write_reg(logic idx, logic [12:0] data);
            if (idx == REG_WIDTH)
                width_reg = data[10:0];
            else
                height_reg = data;
        endfunction

        function logic [7:0] magnitude(int gv, int gh);
            int unsigned sq;
            int unsigned r;
            int unsigned t;
            sq = gv * gv + gh * gh;
            if (sq >= 65025)
                return 8'd255;
            r = 0;
            for (int b = 7; b >= 0; b--)
            begin
                t = r | (1 << b);
                if (t * t <= sq)
                    r = t;
            end
            return r[7:0];
        endfunction

        function logic [1:0] sector(int gv, int gh);
            longint a;
            longint b;
            if (gv == 0)
                return SEC_VERT;
            a = (gh < 0) ? -gh : gh;
            b = (gv < 0) ? -gv : gv;
            if ((a << 24) <= b * longint'(TAN_LOW_Q24))
                return SEC_HORIZ;
            if ((a << 24) > b * longint'(TAN_HIGH_Q24))
                return SEC_VERT;
            return ((gh > 0) == (gv > 0)) ? SEC_POS45 : SEC_NEG45;
        endfunction

        // advance the model by one accepted pixel item
        function void note_pixel(logic [7:0] pix, logic fs);
            int unsigned w;
            int unsigned h;
            int unsigned col;
            int unsigned row;
            int unsigned ci;
            logic [7:0] a;
            logic [7:0] b;
            logic [7:0] mag;
            logic [7:0] c;
            logic [7:0] n1;
            logic [7:0] n2;
            logic [1:0] sec;
            logic [1:0] centre_sec;
            int gv;
            int gh;
            logic re;
            logic fe;
            edge_item_t item;

            w = (width_reg < 5) ? 5 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
            h = (height_reg < 5) ? 5 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
            if (fs)
            begin
                col_cnt = 0;
                row_cnt = 0;
            end
            col = col_cnt;
            row = row_cnt;
            ci  = (col < MAX_WIDTH) ? col : MAX_WIDTH - 1;

            // pixel rows and window
            a = pix_rows[0][ci];
            b = pix_rows[1][ci];
            pix_rows[1][ci] = a;
            pix_rows[0][ci] = pix;
            for (int k = 0; k < 3; k++)
            begin
                pix_win[k][0] = pix_win[k][1];
                pix_win[k][1] = pix_win[k][2];
            end
            pix_win[0][2] = b;
            pix_win[1][2] = a;
            pix_win[2][2] = pix;

            // gradients
            gv = (int'(pix_win[2][0]) + 2 * int'(pix_win[2][1]) + int'(pix_win[2][2]))
               - (int'(pix_win[0][0]) + 2 * int'(pix_win[0][1]) + int'(pix_win[0][2]));
            gh = (int'(pix_win[0][0]) + 2 * int'(pix_win[1][0]) + int'(pix_win[2][0]))
               - (int'(pix_win[0][2]) + 2 * int'(pix_win[1][2]) + int'(pix_win[2][2]));
            mag = magnitude(gv, gh);
            sec = sector(gv, gh);

            centre_sec  = sec_dly;
            sec_dly     = sec_row[ci];
            sec_row[ci] = sec;

            // magnitude rows and window
            a = mag_rows[0][ci];
            b = mag_rows[1][ci];
            mag_rows[1][ci] = a;
            mag_rows[0][ci] = mag;
            for (int k = 0; k < 3; k++)
            begin
                mag_win[k][0] = mag_win[k][1];
                mag_win[k][1] = mag_win[k][2];
            end
            mag_win[0][2] = b;
            mag_win[1][2] = a;
            mag_win[2][2] = mag;

            re = (col >= w - 1);
            fe = re && (row >= h - 1);

            // suppression along the centre's sector
            if (row >= 4 && col >= 4)
            begin
                c = mag_win[1][1];
                case (centre_sec)
                    SEC_HORIZ:
                    begin
                        n1 = mag_win[0][1];
                        n2 = mag_win[2][1];
                    end
                    SEC_VERT:
                    begin
                        n1 = mag_win[1][0];
                        n2 = mag_win[1][2];
                    end
                    SEC_POS45:
                    begin
                        n1 = mag_win[2][2];
                        n2 = mag_win[0][0];
                    end
                    default:
                    begin
                        n1 = mag_win[2][0];
                        n2 = mag_win[0][2];
                    end
                endcase
                if (c < n1 || c < n2)
                    c = 8'd0;
                item.strength  = c;
                item.row_end   = re;
                item.frame_end = fe;
                pending_edges = {pending_edges, item};
            end

            if (re)
            begin
                col_cnt = 0;
                row_cnt = fe ? 0 : row + 1;
            end
            else
                col_cnt = col + 1;
        endfunction

        function void check_edge(logic [7:0] strength, logic re, logic fe);
            edge_item_t want;
            if (pending_edges.size() == 0)
            begin
                $display("%0t: unexpected edge item: expected none, actual %0h/%0b/%0b",
                         $time, strength, re, fe);
                errors++;
                return;
            end
            want = pending_edges.pop_front();
            if (strength !== want.strength)
            begin
                $display("%0t: edge_strength mismatch: expected %0d, actual %0d",
                         $time, want.strength, strength);
                errors++;
            end
            if (re !== want.row_end)
            begin
                $display("%0t: row_end mismatch: expected %0b, actual %0b",
                         $time, want.row_end, re);
                errors++;
            end
            if (fe !== want.frame_end)
            begin
                $display("%0t: frame_end mismatch: expected %0b, actual %0b",
                         $time, want.frame_end, fe);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [12:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    edge_scoreboard sb;
    int tx_idle;
    int rx_idle;
    int rand_items;

    sobel_nonmax_suppression dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver stalls
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= rx_idle);
    end

    // output monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_edge(m_tdata, m_tlast, m_tuser);
    end

    // run limit
    initial
    begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

    // wait for all edge items, then for the pipeline to settle
    task automatic drain();
        while (sb.pending_edges.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_size(logic [12:0] w, logic [12:0] h);
        s_tvalid <= 1'b0;
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= REG_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        sb.write_reg(REG_WIDTH, w);
        cfg_index <= REG_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        sb.write_reg(REG_HEIGHT, h);
        cfg_we <= 1'b0;
    endtask

    task automatic send_pixel(logic [7:0] pix, logic fs);
        int gap;
        gap = 0;
        if ($urandom_range(99) < tx_idle)
            gap = $urandom_range(4, 1);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tuser  <= fs;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_pixel(pix, fs);
    endtask

    // pixel patterns: 0 random, 1 binary, 2 ramp with noise, 3 dim, 4 checker,
    // 5 vertical step, 6 diagonal step, 7 flat
    function automatic logic [7:0] make_pixel(int kind, int r, int c);
        case (kind)
            0: return 8'($urandom);
            1: return $urandom_range(1) ? 8'd255 : 8'd0;
            2: return 8'((r * 23 + c * 37 + $urandom_range(15)) & 255);
            3: return 8'($urandom_range(3));
            4: return ((r + c) & 1) ? 8'd255 : 8'd0;
            5: return (c >= 2) ? 8'd255 : 8'd0;
            6: return (r > c) ? 8'd255 : 8'd0;
            default: return 8'd0;
        endcase
    endfunction

    // one frame; stops early after cut_at pixels when cut_at is positive
    task automatic send_frame(int w, int h, int kind, int cut_at);
        int n;
        n = 0;
        for (int r = 0; r < h; r++)
            for (int c = 0; c < w; c++)
            begin
                if (cut_at > 0 && n >= cut_at)
                    return;
                send_pixel(make_pixel(kind, r, c), (n == 0));
                n++;
                rand_items++;
            end
    endtask

    initial
    begin
        int w;
        int h;
        int frames;
        sb        = new();
        tx_idle   = 0;
        rx_idle   = 0;
        rand_items = 0;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_WIDTH;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: smallest frame with flat, checker, step and diagonal content
        write_size(13'd5, 13'd5);
        send_frame(5, 5, 7, 0);
        send_frame(5, 5, 4, 0);
        send_frame(5, 5, 5, 0);
        send_frame(5, 5, 6, 0);

        // out-of-range settings clamp to the minimum width and maximum height
        write_size(13'd0, 13'd8191);
        send_frame(5, 7, 0, 0);
        send_frame(5, 9, 2, 23);

        // random sizes and content under three idling modes
        while (rand_items < 1200)
        begin
            if (rand_items < 400)
            begin
                tx_idle = 34;
                rx_idle = 57;
            end
            else if (rand_items < 800)
            begin
                tx_idle = 57;
                rx_idle = 34;
            end
            else
            begin
                tx_idle = 0;
                rx_idle = 0;
            end
            w = ($urandom_range(9) == 0) ? $urandom_range(40, 17) : $urandom_range(12, 5);
            h = $urandom_range(9, 5);
            write_size(13'(w), 13'(h));
            frames = $urandom_range(3, 1);
            for (int f = 0; f < frames; f++)
            begin
                if ($urandom_range(99) < 12)
                    send_frame(w, h, $urandom_range(3), $urandom_range(w * h - 1, 1));
                else
                    send_frame(w, h, $urandom_range(3), 0);
            end
        end

        @(posedge clk);
        s_tvalid <= 1'b0;
        drain();
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
